/* hdl/pidc_pkg.sv */
// Shared types and constants for the clamped PID controller.
`timescale 1ns / 1ps
package pidc_pkg;

   // Default sizes of the sample path and the gain fraction.
   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int GAIN_FRAC_BITS_DEF = 8;

   // Fixed widths of the register fields and of the drive.
   localparam int GAIN_BITS     = 16;
   localparam int ILIM_BITS     = 23;
   localparam int OLIM_BITS     = 16;
   localparam int ACC_BITS      = 24;
   localparam int DRIVE_BITS    = 16;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;

   // Register indexes (byte address is four times the index).
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_P         = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_I         = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_D         = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_INTEGRAL_LIMIT = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_OUTPUT_LIMIT   = 3'd4;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic signed [GAIN_BITS-1:0] gain_p;
      logic signed [GAIN_BITS-1:0] gain_i;
      logic signed [GAIN_BITS-1:0] gain_d;
      logic [ILIM_BITS-1:0]        integral_limit;
      logic [OLIM_BITS-1:0]        output_limit;
   } cfg_type;

   // Control that travels with each beat through the pipeline.
   typedef struct packed {
      logic valid;
      logic first;
   } beat_ctrl_type;

endpackage

/* hdl/pidc_csr.sv */
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps
module pidc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pidc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [pidc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [pidc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready,
   output pidc_pkg::cfg_type                 cfg
);
   import pidc_pkg::*;

   cfg_type                 cfg_ff;
   logic                    wr_en;
   logic [CSR_IDX_BITS-1:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_paddr[CSR_ADDR_BITS-1:2];
   assign cfg        = cfg_ff;

   // Register writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_GAIN_P:         cfg_ff.gain_p         <= csr_pwdata[GAIN_BITS-1:0];
            REG_GAIN_I:         cfg_ff.gain_i         <= csr_pwdata[GAIN_BITS-1:0];
            REG_GAIN_D:         cfg_ff.gain_d         <= csr_pwdata[GAIN_BITS-1:0];
            REG_INTEGRAL_LIMIT: cfg_ff.integral_limit <= csr_pwdata[ILIM_BITS-1:0];
            REG_OUTPUT_LIMIT:   cfg_ff.output_limit   <= csr_pwdata[OLIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Read-back of the raw register bits.
   always_comb begin
      case (idx)
         REG_GAIN_P:         csr_prdata = CSR_DATA_BITS'(cfg_ff.gain_p);
         REG_GAIN_I:         csr_prdata = CSR_DATA_BITS'(cfg_ff.gain_i);
         REG_GAIN_D:         csr_prdata = CSR_DATA_BITS'(cfg_ff.gain_d);
         REG_INTEGRAL_LIMIT: csr_prdata = CSR_DATA_BITS'(cfg_ff.integral_limit);
         REG_OUTPUT_LIMIT:   csr_prdata = CSR_DATA_BITS'(cfg_ff.output_limit);
         default:            csr_prdata = '0;
      endcase
   end

endmodule

/* hdl/pidc_error.sv */
// Sample register, error computation and the clamped accumulator state.
`timescale 1ns / 1ps
module pidc_error #(
   parameter int SAMPLE_BITS = pidc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic signed [SAMPLE_BITS-1:0]        measured,
   input  logic signed [SAMPLE_BITS-1:0]        target,
   input  pidc_pkg::cfg_type                    cfg,
   output pidc_pkg::beat_ctrl_type              ctrl,
   output logic signed [SAMPLE_BITS:0]          err,
   output logic signed [SAMPLE_BITS+1:0]        diff,
   output logic signed [pidc_pkg::ACC_BITS-1:0] acc
);
   import pidc_pkg::*;

   localparam int ERR_BITS     = SAMPLE_BITS + 1;
   localparam int DIFF_BITS    = SAMPLE_BITS + 2;
   localparam int ACC_SUM_BITS = ((ACC_BITS > ERR_BITS) ? ACC_BITS : ERR_BITS) + 1;

   // Input register.
   logic                          a_valid_ff;
   logic signed [SAMPLE_BITS-1:0] meas_ff;
   logic signed [SAMPLE_BITS-1:0] targ_ff;

   // Controller state.
   logic signed [ACC_BITS-1:0] acc_ff;
   logic signed [ERR_BITS-1:0] prev_ff;
   logic                       primed_ff;

   // Stage output registers.
   beat_ctrl_type               ctrl_ff;
   logic signed [ERR_BITS-1:0]  err_ff;
   logic signed [DIFF_BITS-1:0] diff_ff;
   logic signed [ACC_BITS-1:0]  accv_ff;

   logic signed [ERR_BITS-1:0]     err_in;
   logic signed [DIFF_BITS-1:0]    diff_in;
   logic signed [ACC_SUM_BITS-1:0] acc_sum;
   logic signed [ACC_SUM_BITS-1:0] lim_pos;
   logic signed [ACC_SUM_BITS-1:0] lim_neg;
   logic signed [ACC_BITS-1:0]     acc_in;

   // Capture a beat whenever the pipeline moves.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         meas_ff <= measured;
         targ_ff <= target;
      end
   end

   // Error, derivative term and the accumulator clamped to the integral limit.
   always_comb begin
      err_in  = {targ_ff[SAMPLE_BITS-1], targ_ff} - {meas_ff[SAMPLE_BITS-1], meas_ff};
      diff_in = DIFF_BITS'(err_in) - DIFF_BITS'(prev_ff);
      acc_sum = ACC_SUM_BITS'(acc_ff) + ACC_SUM_BITS'(err_in);
      lim_pos = $signed(ACC_SUM_BITS'(cfg.integral_limit));
      lim_neg = -lim_pos;
      if (acc_sum > lim_pos) begin
         acc_in = ACC_BITS'(lim_pos);
      end else if (acc_sum < lim_neg) begin
         acc_in = ACC_BITS'(lim_neg);
      end else begin
         acc_in = ACC_BITS'(acc_sum);
      end
   end

   // State update: the first sample only records its error.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         prev_ff   <= '0;
         primed_ff <= 1'b0;
      end else if (advance && a_valid_ff) begin
         primed_ff <= 1'b1;
         prev_ff   <= err_in;
         if (primed_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   // Stage output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff.valid <= a_valid_ff;
         ctrl_ff.first <= !primed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && a_valid_ff) begin
         err_ff  <= err_in;
         diff_ff <= diff_in;
         accv_ff <= acc_in;
      end
   end

   assign ctrl = ctrl_ff;
   assign err  = err_ff;
   assign diff = diff_ff;
   assign acc  = accv_ff;

   // Once primed, the controller stays primed until reset.
   a_primed_holds: assert property (@(posedge clock) disable iff (reset)
      !$fell(primed_ff))
      else $error("primed flag dropped outside reset");

   // A beat marked as the first one leaves the controller primed.
   a_first_primes: assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff.valid && ctrl_ff.first) |-> primed_ff)
      else $error("first beat left controller unprimed");

   // An updated accumulator lies within the limit in force at the update.
   a_acc_clamped: assert property (@(posedge clock) disable iff (reset)
      ($past(advance && a_valid_ff && primed_ff) && !$past(reset)) |->
      ((acc_ff <= $signed(ACC_BITS'($past(cfg.integral_limit)))) &&
       (acc_ff >= -$signed(ACC_BITS'($past(cfg.integral_limit))))))
      else $error("accumulator outside integral limit");

endmodule

/* hdl/pidc_product.sv */
// Registered gain multipliers for the proportional, integral and derivative terms.
`timescale 1ns / 1ps
module pidc_product #(
   parameter int SAMPLE_BITS = pidc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           advance,
   input  pidc_pkg::beat_ctrl_type                        in_ctrl,
   input  logic signed [SAMPLE_BITS:0]                    err,
   input  logic signed [SAMPLE_BITS+1:0]                  diff,
   input  logic signed [pidc_pkg::ACC_BITS-1:0]           acc,
   input  pidc_pkg::cfg_type                              cfg,
   output pidc_pkg::beat_ctrl_type                        ctrl,
   output logic signed [SAMPLE_BITS+pidc_pkg::GAIN_BITS:0] prod_p,
   output logic signed [pidc_pkg::ACC_BITS+pidc_pkg::GAIN_BITS-1:0] prod_i,
   output logic signed [SAMPLE_BITS+pidc_pkg::GAIN_BITS+1:0] prod_d
);
   import pidc_pkg::*;

   localparam int PP_BITS = SAMPLE_BITS + 1 + GAIN_BITS;
   localparam int PI_BITS = ACC_BITS + GAIN_BITS;
   localparam int PD_BITS = SAMPLE_BITS + 2 + GAIN_BITS;

   beat_ctrl_type             ctrl_ff;
   logic signed [PP_BITS-1:0] pp_ff;
   logic signed [PI_BITS-1:0] pi_ff;
   logic signed [PD_BITS-1:0] pd_ff;
   logic signed [PP_BITS-1:0] pp_in;
   logic signed [PI_BITS-1:0] pi_in;
   logic signed [PD_BITS-1:0] pd_in;

   // Three independent signed products.
   assign pp_in = PP_BITS'(err)  * PP_BITS'($signed(cfg.gain_p));
   assign pi_in = PI_BITS'(acc)  * PI_BITS'($signed(cfg.gain_i));
   assign pd_in = PD_BITS'(diff) * PD_BITS'($signed(cfg.gain_d));

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= in_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_ctrl.valid) begin
         pp_ff <= pp_in;
         pi_ff <= pi_in;
         pd_ff <= pd_in;
      end
   end

   assign ctrl   = ctrl_ff;
   assign prod_p = pp_ff;
   assign prod_i = pi_ff;
   assign prod_d = pd_ff;

endmodule

/* hdl/pidc_output.sv */
// Sum of the terms, fraction shift, saturation and the result register.
`timescale 1ns / 1ps
module pidc_output #(
   parameter int SAMPLE_BITS    = pidc_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = pidc_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           advance,
   input  pidc_pkg::beat_ctrl_type                        in_ctrl,
   input  logic signed [SAMPLE_BITS+pidc_pkg::GAIN_BITS:0] prod_p,
   input  logic signed [pidc_pkg::ACC_BITS+pidc_pkg::GAIN_BITS-1:0] prod_i,
   input  logic signed [SAMPLE_BITS+pidc_pkg::GAIN_BITS+1:0] prod_d,
   input  pidc_pkg::cfg_type                              cfg,
   output logic                                           out_valid,
   output logic [pidc_pkg::DRIVE_BITS-1:0]                drive
);
   import pidc_pkg::*;

   localparam int PP_BITS  = SAMPLE_BITS + 1 + GAIN_BITS;
   localparam int PI_BITS  = ACC_BITS + GAIN_BITS;
   localparam int PD_BITS  = SAMPLE_BITS + 2 + GAIN_BITS;
   localparam int MAX_A    = (PP_BITS > PI_BITS) ? PP_BITS : PI_BITS;
   localparam int MAX_B    = (MAX_A > PD_BITS) ? MAX_A : PD_BITS;
   localparam int SUM_BITS = MAX_B + 2;

   logic                        valid_ff;
   logic [DRIVE_BITS-1:0]       drive_ff;
   logic signed [SUM_BITS-1:0]  sum;
   logic signed [SUM_BITS-1:0]  scaled;
   logic signed [SUM_BITS-1:0]  limit;
   logic [DRIVE_BITS-1:0]       drive_in;

   // Exact sum, floor shift by the gain fraction, then saturate to 0 .. limit; a first beat drives zero.
   always_comb begin
      sum    = SUM_BITS'(prod_p) + SUM_BITS'(prod_i) + SUM_BITS'(prod_d);
      scaled = sum >>> GAIN_FRAC_BITS;
      limit  = $signed(SUM_BITS'(cfg.output_limit));
      if (in_ctrl.first || scaled < 0) begin
         drive_in = '0;
      end else if (scaled > limit) begin
         drive_in = cfg.output_limit;
      end else begin
         drive_in = DRIVE_BITS'(scaled);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_ctrl.valid) begin
         drive_ff <= drive_in;
      end
   end

   assign out_valid = valid_ff;
   assign drive     = drive_ff;

endmodule

/* hdl/pid_controller_clamped_core.sv */
// Top level of the clamped PID controller: stream ports, register port and datapath.
// A result beat is offered once its sample beat has passed the input, error and accumulator,
// multiplier and result registers. Throughput: one sample per cycle; the four register
// stages (input, error and accumulator, multipliers, sum and saturation) move together
// whenever the result register is empty or its beat is taken.
// Reset clears the registers, the accumulator, the last error, the primed flag and
// every pipeline valid bit; the block is ready as soon as reset is low.
`timescale 1ns / 1ps
module pid_controller_clamped_core #(
   parameter int SAMPLE_BITS    = pidc_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = pidc_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // Sample channel.
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         req_tdata,  // measured, target
   // Result channel.
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [pidc_pkg::DRIVE_BITS-1:0]            rsp_tdata,  // drive
   // Register port.
   input  logic                                       csr_psel,
   input  logic                                       csr_penable,
   input  logic                                       csr_pwrite,
   input  logic [pidc_pkg::CSR_ADDR_BITS-1:0]         csr_paddr,
   input  logic [pidc_pkg::CSR_DATA_BITS-1:0]         csr_pwdata,
   output logic [pidc_pkg::CSR_DATA_BITS-1:0]         csr_prdata,
   output logic                                       csr_pready
);
   import pidc_pkg::*;

   cfg_type                             cfg;
   logic                                advance;
   logic signed [SAMPLE_BITS-1:0]       measured;
   logic signed [SAMPLE_BITS-1:0]       target;
   beat_ctrl_type                       err_ctrl;
   beat_ctrl_type                       prod_ctrl;
   logic signed [SAMPLE_BITS:0]         err;
   logic signed [SAMPLE_BITS+1:0]       diff;
   logic signed [ACC_BITS-1:0]          acc;
   logic signed [SAMPLE_BITS+GAIN_BITS:0]   prod_p;
   logic signed [ACC_BITS+GAIN_BITS-1:0]    prod_i;
   logic signed [SAMPLE_BITS+GAIN_BITS+1:0] prod_d;

   // The whole pipeline steps when the result register can take a beat.
   // No sample beat is taken while reset is held.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance && !reset;
   assign measured   = req_tdata[SAMPLE_BITS-1:0];
   assign target     = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

   pidc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pidc_error #(.SAMPLE_BITS(SAMPLE_BITS)) u_error (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_tvalid),
      .measured (measured),
      .target   (target),
      .cfg      (cfg),
      .ctrl     (err_ctrl),
      .err      (err),
      .diff     (diff),
      .acc      (acc)
   );

   pidc_product #(.SAMPLE_BITS(SAMPLE_BITS)) u_product (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_ctrl (err_ctrl),
      .err     (err),
      .diff    (diff),
      .acc     (acc),
      .cfg     (cfg),
      .ctrl    (prod_ctrl),
      .prod_p  (prod_p),
      .prod_i  (prod_i),
      .prod_d  (prod_d)
   );

   pidc_output #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_output (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctrl   (prod_ctrl),
      .prod_p    (prod_p),
      .prod_i    (prod_i),
      .prod_d    (prod_d),
      .cfg       (cfg),
      .out_valid (rsp_tvalid),
      .drive     (rsp_tdata)
   );

   // A stalled result beat holds the whole pipeline, so no sample beat is taken.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("sample accepted while result beat is stalled");

endmodule

/* tb/tb_pid_controller_clamped_core.sv */
// Self-checking testbench for the clamped PID controller core: directed cases, random traffic.
`timescale 1ns / 1ps
module tb_pid_controller_clamped_core;
   import pidc_pkg::*;

   localparam int SAMPLE_W      = SAMPLE_BITS_DEF;
   localparam int FRAC_W        = GAIN_FRAC_BITS_DEF;
   localparam int REQ_W         = ((2*SAMPLE_W+7)/8)*8;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 5000;
   localparam int SETTING_BLOCK = 50;
   localparam int PHASE_ITEMS   = 650;

   // One sample beat: measured in the low half, target above it.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] target;
      logic signed [SAMPLE_W-1:0] measured;
   } sample_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata;   // measured, target
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [DRIVE_BITS-1:0]     rsp_tdata;   // drive
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   // Shadow of the register file and of the controller state.
   cfg_type                   ctrl_cfg;
   logic signed [ACC_BITS-1:0] acc_err;
   logic signed [SAMPLE_W:0]  last_err;
   logic                      primed;

   logic [DRIVE_BITS-1:0]     expected_drive[$];

   int send_idle_pct;
   int recv_idle_pct;
   bit hold_request;
   int quiet_cycles;
   int mismatches;
   int samples_sent;
   int drives_checked;
   int reg_writes;
   int long_stalls;

   pid_controller_clamped_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Works out the drive for one sample and advances the shadow state.
   function automatic logic [DRIVE_BITS-1:0] next_drive(sample_type s);
      longint err;
      longint acc;
      longint lim;
      longint total;
      longint drv;
      err = longint'($signed(s.target)) - longint'($signed(s.measured));
      if (!primed) begin
         primed   = 1'b1;
         last_err = err[SAMPLE_W:0];
         return '0;
      end
      // The accumulator is bounded by the integral limit, never the output limit.
      lim = longint'(ctrl_cfg.integral_limit);
      acc = longint'(acc_err) + err;
      if (acc > lim) begin
         acc = lim;
      end else if (acc < -lim) begin
         acc = -lim;
      end
      acc_err = acc[ACC_BITS-1:0];
      total = longint'($signed(ctrl_cfg.gain_p)) * err
            + longint'($signed(ctrl_cfg.gain_i)) * acc
            + longint'($signed(ctrl_cfg.gain_d)) * (err - longint'(last_err));
      drv = total >>> FRAC_W;
      last_err = err[SAMPLE_W:0];
      if (drv > longint'(ctrl_cfg.output_limit)) begin
         drv = longint'(ctrl_cfg.output_limit);
      end
      if (drv < 0) begin
         drv = 0;
      end
      return drv[DRIVE_BITS-1:0];
   endfunction

   // Offers one sample beat and records the expected drive once it is taken.
   task automatic send_sample(sample_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(s);
      do @(posedge clock); while (!req_tready);
      expected_drive.push_back(next_drive(s));
      samples_sent++;
   endtask

   task automatic send_pair(int meas, int targ);
      sample_type s;
      s.measured = SAMPLE_W'(meas);
      s.target   = SAMPLE_W'(targ);
      send_sample(s);
   endtask

   // Lets the pipeline run dry so the registers may be changed.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_drive.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_GAIN_P:         ctrl_cfg.gain_p         = value[GAIN_BITS-1:0];
         REG_GAIN_I:         ctrl_cfg.gain_i         = value[GAIN_BITS-1:0];
         REG_GAIN_D:         ctrl_cfg.gain_d         = value[GAIN_BITS-1:0];
         REG_INTEGRAL_LIMIT: ctrl_cfg.integral_limit = value[ILIM_BITS-1:0];
         REG_OUTPUT_LIMIT:   ctrl_cfg.output_limit   = value[OLIM_BITS-1:0];
         default: ;
      endcase
      reg_writes++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Reads one register back and compares the bits that it defines.
   task automatic read_check(logic [CSR_IDX_BITS-1:0] idx);
      logic [CSR_DATA_BITS-1:0] got;
      logic [CSR_DATA_BITS-1:0] want;
      logic [CSR_DATA_BITS-1:0] mask;
      string                    name;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      case (idx)
         REG_GAIN_P: begin
            name = "gain_p"; want = 32'(ctrl_cfg.gain_p); mask = (32'd1 << GAIN_BITS) - 1;
         end
         REG_GAIN_I: begin
            name = "gain_i"; want = 32'(ctrl_cfg.gain_i); mask = (32'd1 << GAIN_BITS) - 1;
         end
         REG_GAIN_D: begin
            name = "gain_d"; want = 32'(ctrl_cfg.gain_d); mask = (32'd1 << GAIN_BITS) - 1;
         end
         REG_INTEGRAL_LIMIT: begin
            name = "integral_limit"; want = 32'(ctrl_cfg.integral_limit);
            mask = (32'd1 << ILIM_BITS) - 1;
         end
         default: begin
            name = "output_limit"; want = 32'(ctrl_cfg.output_limit);
            mask = (32'd1 << OLIM_BITS) - 1;
         end
      endcase
      if ((got & mask) != (want & mask)) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want & mask, got & mask);
         mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_all(int gp, int gi, int gd, int ilim, int olim);
      write_reg(REG_GAIN_P, gp);
      write_reg(REG_GAIN_I, gi);
      write_reg(REG_GAIN_D, gd);
      write_reg(REG_INTEGRAL_LIMIT, ilim);
      write_reg(REG_OUTPUT_LIMIT, olim);
   endtask

   function automatic int pick_gain();
      case ($urandom_range(5))
         0:       return -32768;
         1:       return 32767;
         5:       return int'($signed(16'($urandom())));
         default: return int'($urandom_range(1024)) - 512;
      endcase
   endfunction

   function automatic int pick_ilim();
      case ($urandom_range(5))
         0:       return 0;
         1:       return 8388607;
         5:       return int'($urandom_range(8388607));
         default: return int'($urandom_range(5000));
      endcase
   endfunction

   function automatic int pick_olim();
      case ($urandom_range(4))
         0:       return 0;
         1:       return 65535;
         default: return int'($urandom_range(65535));
      endcase
   endfunction

   // Mostly near-settled loops with small errors, some wholly random samples.
   function automatic sample_type random_sample();
      sample_type s;
      int         meas;
      s.target = SAMPLE_W'($urandom());
      if ($urandom_range(9) < 2) begin
         s.measured = SAMPLE_W'($urandom());
      end else begin
         meas = int'(s.target) + int'($urandom_range(400)) - 200;
         if (meas > 32767) meas = 32767;
         if (meas < -32768) meas = -32768;
         s.measured = SAMPLE_W'(meas);
      end
      return s;
   endfunction

   // Register writes and readback, with writes beyond the map left without effect.
   task automatic test_register_access();
      set_all(32'h1234_8001, 32'h0000_7FFF, 32'hFFFF_8000, 32'h00FF_FFFF, 32'hABCD_FFFF);
      for (int idx = REG_GAIN_P; idx <= REG_OUTPUT_LIMIT; idx++) begin
         read_check(CSR_IDX_BITS'(idx));
      end
      for (int idx = REG_OUTPUT_LIMIT + 1; idx < 2**CSR_IDX_BITS; idx++) begin
         write_reg(CSR_IDX_BITS'(idx), $urandom());
      end
      for (int idx = REG_GAIN_P; idx <= REG_OUTPUT_LIMIT; idx++) begin
         read_check(CSR_IDX_BITS'(idx));
      end
   endtask

   // The first sample after reset drives zero, whatever the gains.
   task automatic test_first_sample();
      set_all(256, 256, 256, 8388607, 65535);
      send_pair(-32768, 32767);
      wait_idle();
   endtask

   task automatic test_field_extremes();
      send_pair(-32768, 32767);
      send_pair(32767, -32768);
      send_pair(0, 0);
      send_pair(-1, -1);
      send_pair(32767, 32767);
      send_pair(-32768, -32768);
      wait_idle();
   endtask

   // Accumulator driven to both bounds, then the bound lowered with the pipeline idle.
   task automatic test_integral_clamp();
      set_all(0, 256, 0, 100, 65535);
      repeat (4) send_pair(0, 60);
      repeat (4) send_pair(60, 0);
      repeat (4) send_pair(0, 60);
      wait_idle();
      write_reg(REG_INTEGRAL_LIMIT, 20);
      send_pair(0, 0);
      wait_idle();
   endtask

   // Drive held at the output limit, at zero, and with a zero limit.
   task automatic test_output_saturation();
      set_all(32767, 0, -32768, 0, 50);
      send_pair(0, 1000);
      send_pair(1000, 0);
      send_pair(0, 0);
      wait_idle();
      write_reg(REG_OUTPUT_LIMIT, 0);
      send_pair(0, 1000);
      wait_idle();
   endtask

   task automatic test_random_traffic(int send_pct, int recv_pct, int items);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int blk = 0; blk < items / SETTING_BLOCK; blk++) begin
         wait_idle();
         set_all(pick_gain(), pick_gain(), pick_gain(), pick_ilim(), pick_olim());
         repeat (SETTING_BLOCK) send_sample(random_sample());
      end
      wait_idle();
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall the input.
   task automatic test_result_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_all(256, 16, -128, 3000, 40000);
      hold_request = 1'b1;
      repeat (40) send_sample(random_sample());
      wait_idle();
   endtask

   // Result side: random stalls, or one long hold when asked for.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            long_stalls++;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Each drive beat is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_drive.size() == 0) begin
            $error("drive: expected no beat, actual %0d", rsp_tdata);
            mismatches++;
         end else begin
            if (rsp_tdata !== expected_drive[0]) begin
               $error("drive: expected %0d, actual %0d", expected_drive[0], rsp_tdata);
               mismatches++;
            end
            void'(expected_drive.pop_front());
            drives_checked++;
         end
      end
   end

   // Ends the run if nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("pid_controller_clamped_core regression: fail");
         $finish;
      end
   end

   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      ctrl_cfg     = '0;
      acc_err      = '0;
      last_err     = '0;
      primed       = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_first_sample();
      test_field_extremes();
      test_integral_clamp();
      test_output_saturation();
      test_random_traffic(22, 73, PHASE_ITEMS);
      test_random_traffic(73, 22, PHASE_ITEMS);
      test_random_traffic(0, 0, PHASE_ITEMS);
      test_result_backpressure();

      $display("Sent %0d samples and checked %0d drive beats over %0d register writes.",
               samples_sent, drives_checked, reg_writes);
      $display("Covered clamps, saturation, readback and %0d long result stall(s).",
               long_stalls);
      if (mismatches == 0) begin
         $display("pid_controller_clamped_core regression: pass");
      end else begin
         $display("pid_controller_clamped_core regression: fail");
      end
      $finish;
   end

endmodule
